// File: rtl/core/fifo_queue_with_delete_by_id_macros.svh
// Assertion macros for the delete-by-id queue checkers.
// No dependencies; included by the checker file.
`ifndef FIFO_QUEUE_WITH_DELETE_BY_ID_MACROS_SVH
`define FIFO_QUEUE_WITH_DELETE_BY_ID_MACROS_SVH

// Same-cycle implication.
`define FQD_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("queue port check failed");

// Next-cycle implication.
`define FQD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("queue port check failed");

`endif

// File: rtl/core/fqdel_pkg.sv
// Package for the delete-by-id queue: sizes, operation and result codes, transfer types.
// No dependencies.
package fqdel_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned ID_BITS     = 16;
    localparam int unsigned ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned RAM_W       = ID_BITS + 1;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_APPEND  = 2'd0,
        MODE_DELETE  = 2'd1,
        MODE_DEQUEUE = 2'd2,
        MODE_SET_ALL = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RC_OK        = 2'd0,
        RC_EMPTY     = 2'd1,
        RC_FULL      = 2'd2,
        RC_NOT_FOUND = 2'd3
    } t_result;

    typedef struct packed {
        t_mode              mode;
        logic [ID_BITS-1:0] item_id;
        logic               item_status;
    } t_in_item;

    typedef struct packed {
        t_result            result_code;
        logic [ID_BITS-1:0] head_id;
        logic [CNT_W-1:0]   entry_count;
    } t_out_item;

endpackage

// File: rtl/core/fqdel_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fqdel_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/fifo_queue_with_delete_by_id.sv
// Top level of the delete-by-id queue: sequencer stepping one RAM slot per cycle.
// Depends on fqdel_pkg and fqdel_ram.
//
// Ordered queue of up to QUEUE_DEPTH entries (identifier plus status bit), slot 0 the head.
// One command is taken at a time; the input stalls until its result is in the output
// register. Append, and any command that finds the queue empty or full, goes straight
// to the finish state. Delete and dequeue walk the entries through the RAM: scan up to
// the match, then shift the tail down one slot per cycle. Set-all rewrites every held
// entry. A finished result may wait in the output register while the next command is
// taken. No clearing pass after reset.
module fifo_queue_with_delete_by_id (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fqdel_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fqdel_pkg::t_out_item o_out_item
);

    localparam int unsigned AW = fqdel_pkg::ADDR_W;
    localparam int unsigned CW = fqdel_pkg::CNT_W;
    localparam int unsigned IW = fqdel_pkg::ID_BITS;
    localparam int unsigned RW = fqdel_pkg::RAM_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE,
        S_SETS,
        S_FIN
    } t_state;

    t_state               r_state, n_state;
    fqdel_pkg::t_mode     r_mode, n_mode;
    logic [IW-1:0]        r_id, n_id;
    logic [AW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_cnt, n_cnt;
    fqdel_pkg::t_result   r_code, n_code;
    logic [IW-1:0]        r_head, n_head;
    logic                 r_out_valid, n_out_valid;
    fqdel_pkg::t_out_item r_out_item, n_out_item;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;
    logic [IW-1:0] rd_id;
    logic [CW-1:0] idx_p1;
    logic [CW-1:0] idx_p2;

    fqdel_ram #(
        .WIDTH (RW),
        .DEPTH (fqdel_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_id  = ram_rdata[IW-1:0];
    assign idx_p1 = CW'(r_idx) + CW'(1);
    assign idx_p2 = CW'(r_idx) + CW'(2);

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_id        = r_id;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_code      = r_code;
        n_head      = r_head;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        ram_we      = 1'b0;
        ram_waddr   = r_idx;
        ram_wdata   = ram_rdata;
        ram_raddr   = r_idx;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode    = i_in_item.mode;
                    n_id      = i_in_item.item_id;
                    n_head    = '0;
                    n_code    = fqdel_pkg::RC_OK;
                    n_idx     = '0;
                    ram_raddr = '0;
                    n_state   = S_FIN;
                    case (i_in_item.mode)
                        fqdel_pkg::MODE_APPEND: begin
                            if (r_cnt == fqdel_pkg::FULL_COUNT) begin
                                n_code = fqdel_pkg::RC_FULL;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(r_cnt);
                                ram_wdata = {i_in_item.item_status, i_in_item.item_id};
                                n_cnt     = r_cnt + CW'(1);
                            end
                        end
                        fqdel_pkg::MODE_DELETE: begin
                            if (r_cnt == '0) begin
                                n_code = fqdel_pkg::RC_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        fqdel_pkg::MODE_DEQUEUE: begin
                            if (r_cnt == '0) begin
                                n_code = fqdel_pkg::RC_EMPTY;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            if (r_cnt != '0) begin
                                n_state = S_SETS;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_mode == fqdel_pkg::MODE_DEQUEUE || rd_id == r_id) begin
                    if (r_mode == fqdel_pkg::MODE_DEQUEUE) begin
                        n_head = rd_id;
                    end
                    if (idx_p1 < r_cnt) begin
                        ram_raddr = AW'(idx_p1);
                        n_state   = S_MOVE;
                    end else begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = S_FIN;
                    end
                end else if (idx_p1 < r_cnt) begin
                    n_idx     = r_idx + AW'(1);
                    ram_raddr = AW'(idx_p1);
                end else begin
                    n_code  = fqdel_pkg::RC_NOT_FOUND;
                    n_state = S_FIN;
                end
            end
            S_MOVE: begin
                // rdata holds slot idx+1; move it down into idx
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = ram_rdata;
                n_idx     = r_idx + AW'(1);
                if (idx_p2 < r_cnt) begin
                    ram_raddr = AW'(idx_p2);
                end else begin
                    n_cnt   = r_cnt - CW'(1);
                    n_state = S_FIN;
                end
            end
            S_SETS: begin
                ram_we    = 1'b1;
                ram_waddr = r_idx;
                ram_wdata = {1'b1, rd_id};
                if (idx_p1 < r_cnt) begin
                    n_idx     = r_idx + AW'(1);
                    ram_raddr = AW'(idx_p1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid            = 1'b1;
                    n_out_item.result_code = r_code;
                    n_out_item.head_id     = r_head;
                    n_out_item.entry_count = r_cnt;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_id       <= n_id;
        r_idx      <= n_idx;
        r_code     <= n_code;
        r_head     <= n_head;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// File: rtl/core/fqdel_checker.sv
// Port-level checks for the delete-by-id queue, bound to the top level.
// Depends on fqdel_pkg and fifo_queue_with_delete_by_id_macros.svh.
`include "fifo_queue_with_delete_by_id_macros.svh"

module fqdel_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input fqdel_pkg::t_in_item  i_in_item,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input fqdel_pkg::t_out_item o_out_item
);

    `FQD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))
    `FQD_ASSERT(a_count_range, i_clk, i_rst_n, o_out_valid, o_out_item.entry_count <= fqdel_pkg::FULL_COUNT)
    `FQD_ASSERT(a_head_only_ok, i_clk, i_rst_n, o_out_valid && o_out_item.head_id != '0, o_out_item.result_code == fqdel_pkg::RC_OK)
    `FQD_ASSERT(a_full_count, i_clk, i_rst_n, o_out_valid && o_out_item.result_code == fqdel_pkg::RC_FULL, o_out_item.entry_count == fqdel_pkg::FULL_COUNT)
    `FQD_ASSERT_NEXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind fifo_queue_with_delete_by_id fqdel_checker u_fqdel_checker (.*);
